// ===== rtl/ktsor_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ktsor_pkg
// Shared types and constants for the keyed trace store with oldest-entry
// replacement.
// ----------------------------------------------------------------------------
package ktsor_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int TAG_W       = 32;
    localparam int AGE_W       = 32;
    localparam int STAMP_W     = 32;
    localparam int HOPS_W      = 8;
    localparam int SNR_W       = 8;
    localparam int SLOT_W      = 4;

    // item operation codes
    localparam logic OP_STORE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_FETCH  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    // what the scan has seen so far
    typedef struct packed {
        logic hit;
        logic free_found;
        logic age_found;
    } t_scan_flags;

endpackage : ktsor_pkg
`default_nettype wire

// ===== rtl/ktsor_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ktsor_scan
// Accumulates one entry per cycle while the table is swept: first tag match,
// first free slot and oldest valid entry (strictly smaller age wins, so the
// lowest index is kept on a tie).
// ----------------------------------------------------------------------------
module ktsor_scan #(
    parameter int ENTRIES = ktsor_pkg::ENTRIES_DEF,
    localparam int IW     = $clog2(ENTRIES)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_act,
    input  wire logic [IW-1:0]              i_idx,
    input  wire logic                       i_valid,
    input  wire logic [ktsor_pkg::TAG_W-1:0] i_key,
    input  wire logic [ktsor_pkg::AGE_W-1:0] i_age,
    input  wire logic [ktsor_pkg::TAG_W-1:0] i_tag,
    output ktsor_pkg::t_scan_flags          o_flags,
    output logic [IW-1:0]                   o_match,
    output logic [IW-1:0]                   o_free,
    output logic [IW-1:0]                   o_oldest
);
    import ktsor_pkg::*;

    t_scan_flags      r_flags, n_flags;
    logic [IW-1:0]    r_match, n_match;
    logic [IW-1:0]    r_free, n_free;
    logic [IW-1:0]    r_oldest, n_oldest;
    logic [AGE_W-1:0] r_oldest_age, n_oldest_age;

    // fold the entry now read into the running results
    always_comb begin
        n_flags      = r_flags;
        n_match      = r_match;
        n_free       = r_free;
        n_oldest     = r_oldest;
        n_oldest_age = r_oldest_age;
        if (i_clear) begin
            n_flags = '0;
        end else if (i_act) begin
            if (i_valid && (i_key == i_tag) && !r_flags.hit) begin
                n_flags.hit = 1'b1;
                n_match     = i_idx;
            end
            if (!i_valid && !r_flags.free_found) begin
                n_flags.free_found = 1'b1;
                n_free             = i_idx;
            end
            if (i_valid && (!r_flags.age_found || (i_age < r_oldest_age))) begin
                n_flags.age_found = 1'b1;
                n_oldest          = i_idx;
                n_oldest_age      = i_age;
            end
        end
    end

    // clear flags under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else begin
            r_flags <= n_flags;
        end
    end

    // hold indices and oldest age
    always_ff @(posedge i_clk) begin
        r_match      <= n_match;
        r_free       <= n_free;
        r_oldest     <= n_oldest;
        r_oldest_age <= n_oldest_age;
    end

    assign o_flags  = r_flags;
    assign o_match  = r_match;
    assign o_free   = r_free;
    assign o_oldest = r_oldest;

endmodule : ktsor_scan
`default_nettype wire

// ===== rtl/keyed_trace_store_oldest_replace.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_trace_store_oldest_replace
// Table of trace records keyed by tag. A store overwrites the matching entry,
// else the lowest free one, else the one with the smallest age stamp. A
// lookup returns the lowest matching valid entry or a miss.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------------
//   in      | input     | i_in_valid / o_in_stall    | opcode tag hops snr now
//   out     | output    | o_out_valid / i_out_stall  | found slot evicted data
//
// An item is accepted, then the key/age memory is swept one entry a cycle
// through its single read port, then the item passes drain, data fetch and
// finish. Reset (synchronous, active low) clears the valid bits, the write
// counter and the sequencer; memory contents are not cleared.
// A stalled output holds the item in finish until the result register frees;
// the next word is taken while an earlier result still waits.
// ----------------------------------------------------------------------------
module keyed_trace_store_oldest_replace #(
    parameter int ENTRIES = ktsor_pkg::ENTRIES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_opcode,
    input  wire logic [ktsor_pkg::TAG_W-1:0]        i_tag,
    input  wire logic [ktsor_pkg::HOPS_W-1:0]       i_hops,
    input  wire logic signed [ktsor_pkg::SNR_W-1:0] i_snr_out,
    input  wire logic signed [ktsor_pkg::SNR_W-1:0] i_snr_return,
    input  wire logic [ktsor_pkg::STAMP_W-1:0]      i_now_ms,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_found,
    output logic [ktsor_pkg::SLOT_W-1:0]            o_slot,
    output logic                                    o_evicted,
    output logic [ktsor_pkg::HOPS_W-1:0]            o_hops_out,
    output logic signed [ktsor_pkg::SNR_W-1:0]      o_snr_out_read,
    output logic signed [ktsor_pkg::SNR_W-1:0]      o_snr_return_read,
    output logic [ktsor_pkg::STAMP_W-1:0]           o_stamp_read
);
    import ktsor_pkg::*;

    localparam int IW     = $clog2(ENTRIES);
    localparam int KA_W   = AGE_W + TAG_W;
    localparam int DM_W   = STAMP_W + 2 * SNR_W + HOPS_W;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // memories: key with age stamp, and record data
    logic [KA_W-1:0] ka_mem [ENTRIES];
    logic [DM_W-1:0] dm_mem [ENTRIES];
    logic [KA_W-1:0] r_ka_q;
    logic [DM_W-1:0] r_dm_q;

    t_state               r_state, n_state;
    logic [ENTRIES-1:0]   r_valid;
    logic [AGE_W-1:0]     r_counter;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_cmp_idx;
    logic                 r_cmp_act;

    // held input word
    logic                 r_op;
    logic [TAG_W-1:0]     r_tag;
    logic [HOPS_W-1:0]    r_hops;
    logic [SNR_W-1:0]     r_snr_o;
    logic [SNR_W-1:0]     r_snr_r;
    logic [STAMP_W-1:0]   r_now;

    // result register
    logic                 r_out_valid;
    logic                 r_found;
    logic [SLOT_W-1:0]    r_slot;
    logic                 r_evicted;
    logic [HOPS_W-1:0]    r_hops_out;
    logic [SNR_W-1:0]     r_snr_o_out;
    logic [SNR_W-1:0]     r_snr_r_out;
    logic [STAMP_W-1:0]   r_stamp_out;

    t_scan_flags          scan_flags;
    logic [IW-1:0]        scan_match;
    logic [IW-1:0]        scan_free;
    logic [IW-1:0]        scan_oldest;

    logic                 in_acc;
    logic                 out_acc;
    logic                 out_free;
    logic                 finish;
    logic                 wr_en;
    logic [IW-1:0]        sel;
    logic                 ev;
    logic [AGE_W-1:0]     n_counter;
    logic [IW+SLOT_W-1:0] sel_ext;
    logic [IW+SLOT_W-1:0] match_ext;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_acc   = r_out_valid && !i_out_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign finish    = (r_state == ST_FINISH) && out_free;
    assign wr_en     = finish && (r_op == OP_STORE);
    assign n_counter = r_counter + AGE_W'(1);
    assign ev        = !scan_flags.hit && !scan_flags.free_found;
    assign sel_ext   = {{SLOT_W{1'b0}}, sel};
    assign match_ext = {{SLOT_W{1'b0}}, scan_match};

    // pick the entry a store writes
    always_comb begin
        if (scan_flags.hit) begin
            sel = scan_match;
        end else if (scan_flags.free_found) begin
            sel = scan_free;
        end else begin
            sel = scan_oldest;
        end
    end

    // sequence one item through sweep, drain, fetch and finish
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_acc) n_state = ST_SCAN;
            ST_SCAN:   if (r_idx == LAST) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_FETCH;
            ST_FETCH:  n_state = ST_FINISH;
            ST_FINISH: if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_counter   <= '0;
            r_cmp_act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_act <= (r_state == ST_SCAN);
            if (wr_en) begin
                r_valid[sel] <= 1'b1;
                r_counter    <= n_counter;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // capture the input word and advance the sweep address
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (in_acc) begin
            r_op    <= i_opcode;
            r_tag   <= i_tag;
            r_hops  <= i_hops;
            r_snr_o <= i_snr_out;
            r_snr_r <= i_snr_return;
            r_now   <= i_now_ms;
            r_idx   <= '0;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // memory ports: one write, one registered read each
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ka_mem[sel] <= {n_counter, r_tag};
            dm_mem[sel] <= {r_now, r_snr_r, r_snr_o, r_hops};
        end
        r_ka_q <= ka_mem[r_idx];
        r_dm_q <= dm_mem[scan_match];
    end

    ktsor_scan #(
        .ENTRIES (ENTRIES)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (in_acc),
        .i_act    (r_cmp_act),
        .i_idx    (r_cmp_idx),
        .i_valid  (r_valid[r_cmp_idx]),
        .i_key    (r_ka_q[TAG_W-1:0]),
        .i_age    (r_ka_q[KA_W-1:TAG_W]),
        .i_tag    (r_tag),
        .o_flags  (scan_flags),
        .o_match  (scan_match),
        .o_free   (scan_free),
        .o_oldest (scan_oldest)
    );

    // load the result word
    always_ff @(posedge i_clk) begin
        if (finish) begin
            if (r_op == OP_STORE) begin
                r_found     <= scan_flags.hit;
                r_slot      <= sel_ext[SLOT_W-1:0];
                r_evicted   <= ev;
                r_hops_out  <= r_hops;
                r_snr_o_out <= r_snr_o;
                r_snr_r_out <= r_snr_r;
                r_stamp_out <= r_now;
            end else if (scan_flags.hit) begin
                r_found     <= 1'b1;
                r_slot      <= match_ext[SLOT_W-1:0];
                r_evicted   <= 1'b0;
                r_hops_out  <= r_dm_q[HOPS_W-1:0];
                r_snr_o_out <= r_dm_q[HOPS_W +: SNR_W];
                r_snr_r_out <= r_dm_q[HOPS_W+SNR_W +: SNR_W];
                r_stamp_out <= r_dm_q[DM_W-1 -: STAMP_W];
            end else begin
                r_found     <= 1'b0;
                r_slot      <= '0;
                r_evicted   <= 1'b0;
                r_hops_out  <= '0;
                r_snr_o_out <= '0;
                r_snr_r_out <= '0;
                r_stamp_out <= '0;
            end
        end
    end

    assign o_in_stall        = (r_state != ST_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_found           = r_found;
    assign o_slot            = r_slot;
    assign o_evicted         = r_evicted;
    assign o_hops_out        = r_hops_out;
    assign o_snr_out_read    = r_snr_o_out;
    assign o_snr_return_read = r_snr_r_out;
    assign o_stamp_read      = r_stamp_out;

    // valid bits only ever set outside reset
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_valid & $past(r_valid)) == $past(r_valid)))
        else $error("valid bit dropped");

    // write counter moves only on a completed store
    a_counter_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> $stable(r_counter))
        else $error("write counter moved without a store");

    // a completed store leaves its entry valid
    a_store_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> r_valid[$past(sel)])
        else $error("stored entry not marked valid");

    // a result appears only from the finish step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("result loaded outside finish");

endmodule : keyed_trace_store_oldest_replace
`default_nettype wire
